@@ rtl/ddpid_pkg.sv @@
// Shared types and constants for the differential drive PID block.
package ddpid_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MULI,
    ST_DELTA,
    ST_DONE
  } state_t;

  // configuration register indexes
  localparam logic [2:0] REG_PROP_GAIN       = 3'd0;
  localparam logic [2:0] REG_INTEG_GAIN      = 3'd1;
  localparam logic [2:0] REG_DERIV_GAIN      = 3'd2;
  localparam logic [2:0] REG_TURN_SLOW       = 3'd3;
  localparam logic [2:0] REG_BASE_SPEED      = 3'd4;
  localparam logic [2:0] REG_OVERSPEED_LIMIT = 3'd5;

  localparam int GAIN_W     = 12;
  localparam int ERR_W      = 12;
  localparam int ENC_W      = 16;
  localparam int DUTY_W     = 16;
  localparam int LIMIT_W    = 15;
  localparam int INTEG_W    = 32;
  localparam int CFG_W      = 16;

  // |9*old + 10*err| stays below 2^35
  localparam int DIV_STEPS  = 35;
  localparam logic [4:0] DIVISOR = 5'd10;

  localparam logic [DUTY_W-1:0] DUTY_MAX       = 16'd45000;
  localparam logic [DUTY_W-1:0] DUTY_OVERSPEED = 16'd5000;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 15'd32767;

endpackage

@@ rtl/differential_drive_pid.sv @@
// Differential drive steering PID with leaky integral, bit-serial datapath.
// A new input beat is accepted only in idle, after the previous result is loaded to the output.
// Each item runs the 35-step restoring divide by 10 of the integral update
// followed by the 12-step serial integral-gain multiply.
// The proportional, derivative and slowdown products run during the divide.
// Reset (rst, synchronous): gains, base speed and integral cleared, overspeed limit 32767.
module differential_drive_pid (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [11:0] steer_error, [27:12] encoder_count, [31:28] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [15:0] left_duty, [31:16] right_duty
  output logic        m_tuser,   // [0] overspeed
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_data
);

  localparam int GW = ddpid_pkg::GAIN_W;

  // configuration
  logic [GW-1:0]                    prop_gain, integ_gain, deriv_gain, turn_slow;
  logic [ddpid_pkg::DUTY_W-1:0]     base_speed;
  logic [ddpid_pkg::LIMIT_W-1:0]    overspeed_limit;

  // state
  logic signed [31:0] error_integral;
  logic signed [11:0] previous_error;

  ddpid_pkg::state_t state, state_next;
  logic [5:0]  cnt;

  // per-item working registers
  logic signed [11:0] err;
  logic signed [12:0] err_diff;
  logic [11:0]        err_mag;
  logic               over;
  logic               neg;
  logic [34:0]        dq;
  logic [3:0]         rem;
  logic [GW-1:0]      g_p, g_d, g_s, g_i;
  logic signed [25:0] acc_pd;
  logic [23:0]        acc_s;
  logic signed [43:0] acc_i;
  logic signed [43:0] delta;
  logic signed [24:0] bms;

  logic accept, load_out, out_free;

  // input fields
  logic signed [11:0] in_err;
  logic signed [15:0] in_enc;
  assign in_err = s_tdata[11:0];
  assign in_enc = s_tdata[27:12];

  // 9*old + 10*err
  logic signed [35:0] old_ext, err_ext, s_sum, s_neg;
  assign old_ext = {{4{error_integral[31]}}, error_integral};
  assign err_ext = {{24{in_err[11]}}, in_err};
  assign s_sum   = (old_ext <<< 3) + old_ext + (err_ext <<< 3) + (err_ext <<< 1);
  assign s_neg   = -s_sum;

  logic signed [16:0] over_sum;
  assign over_sum = {in_enc[15], in_enc} + {2'b00, overspeed_limit};

  logic signed [12:0] in_diff, in_err13;
  assign in_err13 = {in_err[11], in_err};
  assign in_diff  = in_err13 - {previous_error[11], previous_error};

  logic [12:0] in_neg13;
  assign in_neg13 = -in_err13;

  // restoring divide by ten, one quotient bit per cycle
  logic [4:0]  div_t;
  logic        q_bit;
  logic [4:0]  div_r;
  logic [34:0] dq_next;
  assign div_t   = {rem, dq[34]};
  assign q_bit   = div_t >= ddpid_pkg::DIVISOR;
  assign div_r   = q_bit ? div_t - ddpid_pkg::DIVISOR : div_t;
  assign dq_next = {dq[33:0], q_bit};

  // the leak keeps |integral| under 0.9*2^31 + 2048, so the 32-bit
  // saturation never engages and the quotient fits in 31 bits
  logic signed [31:0] q_pos, integ_val;
  assign q_pos     = {1'b0, dq_next[30:0]};
  assign integ_val = neg ? -q_pos : q_pos;

  // MSB-first shift-add multiply steps
  logic signed [25:0] acc_pd_next;
  logic [23:0]        acc_s_next;
  logic signed [43:0] acc_i_next;
  assign acc_pd_next = (acc_pd <<< 1)
                     + (g_p[GW-1] ? {{14{err[11]}}, err} : 26'sd0)
                     + (g_d[GW-1] ? {{13{err_diff[12]}}, err_diff} : 26'sd0);
  assign acc_s_next  = (acc_s << 1) + (g_s[GW-1] ? {12'b0, err_mag} : 24'd0);
  assign acc_i_next  = (acc_i <<< 1)
                     + (g_i[GW-1] ? {{12{error_integral[31]}}, error_integral} : 44'sd0);

  // delta = trunc(sum / 2)
  logic signed [44:0] pid_sum, pid_rnd;
  assign pid_sum = {acc_i[43], acc_i} + {{19{acc_pd[25]}}, acc_pd};
  assign pid_rnd = pid_sum + {44'b0, pid_sum[44]};

  logic signed [45:0] left_raw, right_raw, bms_ext, delta_ext;
  assign bms_ext   = {{21{bms[24]}}, bms};
  assign delta_ext = {{2{delta[43]}}, delta};
  assign left_raw  = bms_ext - delta_ext;
  assign right_raw = bms_ext + delta_ext;

  function automatic logic [15:0] clamp_duty(input logic signed [45:0] d);
    logic signed [45:0] hi;
    hi = $signed({30'b0, ddpid_pkg::DUTY_MAX});
    if (d < 46'sd0) return 16'd0;
    else if (d > hi) return ddpid_pkg::DUTY_MAX;
    else return d[15:0];
  endfunction

  assign out_free = !m_tvalid || m_tready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ddpid_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      ddpid_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = ddpid_pkg::ST_DIV;
      end
      ddpid_pkg::ST_DIV: begin
        if (cnt == 6'(ddpid_pkg::DIV_STEPS - 1)) state_next = ddpid_pkg::ST_MULI;
      end
      ddpid_pkg::ST_MULI: begin
        if (cnt == 6'(GW - 1)) state_next = ddpid_pkg::ST_DELTA;
      end
      ddpid_pkg::ST_DELTA: begin
        state_next = ddpid_pkg::ST_DONE;
      end
      ddpid_pkg::ST_DONE: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = ddpid_pkg::ST_IDLE;
        end
      end
      default: state_next = ddpid_pkg::ST_IDLE;
    endcase
  end

  assign accept = s_tvalid && s_tready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain       <= '0;
      integ_gain      <= '0;
      deriv_gain      <= '0;
      turn_slow       <= '0;
      base_speed      <= '0;
      overspeed_limit <= ddpid_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ddpid_pkg::REG_PROP_GAIN:       prop_gain       <= cfg_data[GW-1:0];
        ddpid_pkg::REG_INTEG_GAIN:      integ_gain      <= cfg_data[GW-1:0];
        ddpid_pkg::REG_DERIV_GAIN:      deriv_gain      <= cfg_data[GW-1:0];
        ddpid_pkg::REG_TURN_SLOW:       turn_slow       <= cfg_data[GW-1:0];
        ddpid_pkg::REG_BASE_SPEED:      base_speed      <= cfg_data;
        ddpid_pkg::REG_OVERSPEED_LIMIT: overspeed_limit <= cfg_data[ddpid_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // control state: counter, loop state, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt            <= '0;
      error_integral <= '0;
      previous_error <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (state_next != state) cnt <= '0;
      else                     cnt <= cnt + 6'd1;
      if (accept) previous_error <= in_err;
      if (state == ddpid_pkg::ST_DIV && state_next == ddpid_pkg::ST_MULI)
        error_integral <= integ_val;
      if (load_out)           m_tvalid <= 1'b1;
      else if (m_tready)      m_tvalid <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      err      <= in_err;
      err_diff <= in_diff;
      err_mag  <= in_err[11] ? in_neg13[11:0] : in_err13[11:0];
      over     <= over_sum[16];
      neg      <= s_sum[35];
      dq       <= s_sum[35] ? s_neg[34:0] : s_sum[34:0];
      rem      <= '0;
      g_p      <= prop_gain;
      g_d      <= deriv_gain;
      g_s      <= turn_slow;
      g_i      <= integ_gain;
      acc_pd   <= '0;
      acc_s    <= '0;
      acc_i    <= '0;
    end
    if (state == ddpid_pkg::ST_DIV) begin
      dq  <= dq_next;
      rem <= div_r[3:0];
      if (cnt < 6'(GW)) begin
        acc_pd <= acc_pd_next;
        acc_s  <= acc_s_next;
        g_p    <= g_p << 1;
        g_d    <= g_d << 1;
        g_s    <= g_s << 1;
      end
    end
    if (state == ddpid_pkg::ST_MULI) begin
      acc_i <= acc_i_next;
      g_i   <= g_i << 1;
    end
    if (state == ddpid_pkg::ST_DELTA) begin
      delta <= pid_rnd[44:1];
      bms   <= {9'b0, base_speed} - {1'b0, acc_s};
    end
    if (load_out) begin
      if (over) begin
        m_tdata <= {ddpid_pkg::DUTY_OVERSPEED, ddpid_pkg::DUTY_OVERSPEED};
      end else begin
        m_tdata <= {clamp_duty(right_raw), clamp_duty(left_raw)};
      end
      m_tuser <= over;
    end
  end

endmodule
